@@ rtl/core/iupac_pattern_search_unit_macros.svh @@
// ----------------------------------------------------------------------------
// IUPAC pattern search unit - assertion macros
// Shared concurrent assertion forms for the search unit modules.
// ----------------------------------------------------------------------------
`ifndef IUPAC_PATTERN_SEARCH_UNIT_MACROS_SVH
`define IUPAC_PATTERN_SEARCH_UNIT_MACROS_SVH

// Check the consequent in the same cycle as the antecedent.
`define IUPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define IUPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/iups_pkg.sv @@
// ----------------------------------------------------------------------------
// IUPAC pattern search package
// Beat types, register codes and the per-character IUPAC match rule.
// ----------------------------------------------------------------------------
`default_nettype none

package iups_pkg;

    localparam int CHAR_W    = 8;
    localparam int PAT_CHARS = 16;
    localparam int LEN_W     = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 64;
    localparam int START_W   = 32;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN  = 2'd2;

    // ASCII codes used by the match rule
    localparam logic [7:0] ASC_LOW_A = 8'h61;
    localparam logic [7:0] ASC_LOW_Z = 8'h7A;
    localparam logic [7:0] ASC_CASE  = 8'h20;
    localparam logic [7:0] ASC_A = 8'h41;
    localparam logic [7:0] ASC_B = 8'h42;
    localparam logic [7:0] ASC_C = 8'h43;
    localparam logic [7:0] ASC_D = 8'h44;
    localparam logic [7:0] ASC_G = 8'h47;
    localparam logic [7:0] ASC_H = 8'h48;
    localparam logic [7:0] ASC_K = 8'h4B;
    localparam logic [7:0] ASC_M = 8'h4D;
    localparam logic [7:0] ASC_N = 8'h4E;
    localparam logic [7:0] ASC_R = 8'h52;
    localparam logic [7:0] ASC_S = 8'h53;
    localparam logic [7:0] ASC_T = 8'h54;
    localparam logic [7:0] ASC_U = 8'h55;
    localparam logic [7:0] ASC_V = 8'h56;
    localparam logic [7:0] ASC_W = 8'h57;
    localparam logic [7:0] ASC_Y = 8'h59;
    localparam logic [7:0] ASC_Z = 8'h5A;

    typedef struct packed {
        logic [CHAR_W-1:0] subject_char;
        logic              first_of_sequence;
    } t_in_item;

    typedef struct packed {
        logic               hit;
        logic [START_W-1:0] start_position;
    } t_out_item;

    typedef struct packed {
        logic [PAT_CHARS*CHAR_W-1:0] pattern_chars;
        logic [LEN_W-1:0]            pattern_length;
    } t_cfg;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        if (c >= ASC_LOW_A && c <= ASC_LOW_Z) begin
            return c - ASC_CASE;
        end
        return c;
    endfunction

    // One-hot bit of a capital letter within the A..Z set
    function automatic logic [25:0] lb(input logic [7:0] c);
        logic [7:0] off;
        off = c - ASC_A;
        return 26'(1) << off[4:0];
    endfunction

    // True when pattern code p accepts subject byte s
    function automatic logic char_matches(input logic [7:0] p, input logic [7:0] s);
        logic [7:0]  up;
        logic [7:0]  us;
        logic [7:0]  off;
        logic [25:0] acc;
        logic        any;
        up  = upcase(p);
        us  = upcase(s);
        off = us - ASC_A;
        acc = '0;
        any = 1'b0;
        unique case (up)
            ASC_C: acc = lb(ASC_C);
            ASC_T: acc = lb(ASC_T);
            ASC_U: acc = lb(ASC_U);
            ASC_A: acc = lb(ASC_A);
            ASC_G: acc = lb(ASC_G);
            ASC_Y: acc = lb(ASC_C) | lb(ASC_T) | lb(ASC_U) | lb(ASC_Y);
            ASC_R: acc = lb(ASC_A) | lb(ASC_G) | lb(ASC_R);
            ASC_W: acc = lb(ASC_A) | lb(ASC_T) | lb(ASC_U) | lb(ASC_W);
            ASC_S: acc = lb(ASC_C) | lb(ASC_G) | lb(ASC_S);
            ASC_K: acc = lb(ASC_G) | lb(ASC_T) | lb(ASC_U) | lb(ASC_K);
            ASC_M: acc = lb(ASC_C) | lb(ASC_A) | lb(ASC_M);
            ASC_B: acc = lb(ASC_C) | lb(ASC_G) | lb(ASC_T) | lb(ASC_U) | lb(ASC_B);
            ASC_D: acc = lb(ASC_A) | lb(ASC_G) | lb(ASC_T) | lb(ASC_U) | lb(ASC_D);
            ASC_H: acc = lb(ASC_A) | lb(ASC_C) | lb(ASC_T) | lb(ASC_U) | lb(ASC_H);
            ASC_V: acc = lb(ASC_A) | lb(ASC_C) | lb(ASC_G) | lb(ASC_V);
            // N and every non-IUPAC byte are wildcards
            ASC_N:   any = 1'b1;
            default: any = 1'b1;
        endcase
        if (any) begin
            return 1'b1;
        end
        if (us < ASC_A || us > ASC_Z) begin
            return 1'b0;
        end
        return acc[off[4:0]];
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/iups_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// IUPAC pattern search - configuration registers
// Holds the pattern characters and pattern length written over the config port.
// ----------------------------------------------------------------------------
`default_nettype none

module iups_cfg_regs
    import iups_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    logic [CFG_DATA_W-1:0] r_pat_low;
    logic [CFG_DATA_W-1:0] r_pat_high;
    logic [LEN_W-1:0]      r_pat_len;

    // Take a write beat in every cycle
    assign o_cfg_ready = 1'b1;

    // Decode the register index; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_pat_len  <= LEN_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PAT_LOW:  r_pat_low  <= i_cfg_data;
                CFG_PAT_HIGH: r_pat_high <= i_cfg_data;
                CFG_PAT_LEN:  r_pat_len  <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg.pattern_chars  = {r_pat_high, r_pat_low};
    assign o_cfg.pattern_length = r_pat_len;

endmodule

`default_nettype wire

@@ rtl/core/iups_input_reg.sv @@
// ----------------------------------------------------------------------------
// IUPAC pattern search - input register
// Registers one subject beat and hands it to the match stage.
// ----------------------------------------------------------------------------
`default_nettype none

module iups_input_reg
    import iups_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_item i_item,
    output logic          o_valid,
    input  wire logic     i_down_ready,
    output t_in_item      o_item
);

    logic     r_valid;
    t_in_item r_item;

    // Accept while empty or while the held beat moves on
    assign o_ready = !r_valid || i_down_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Load payload on accept
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

@@ rtl/core/iups_match_stage.sv @@
// ----------------------------------------------------------------------------
// IUPAC pattern search - window and match stage
// Shifts the subject window, counts positions and compares the pattern
// against the window ending at the new character, into a result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "iupac_pattern_search_unit_macros.svh"

module iups_match_stage
    import iups_pkg::*;
#(
    parameter int MAX_PATTERN   = 16,
    parameter int POSITION_BITS = 32
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_item i_item,
    input  wire t_cfg     i_cfg,
    output logic          o_valid,
    input  wire logic     i_out_ready,
    output t_out_item     o_item
);

    localparam int CAP       = (MAX_PATTERN < PAT_CHARS) ? MAX_PATTERN : PAT_CHARS;
    localparam int WIN_IDX_W = (CAP > 1) ? $clog2(CAP) : 1;
    localparam int SW        = (POSITION_BITS > START_W) ? POSITION_BITS : START_W;
    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    logic [CHAR_W-1:0]        r_win [CAP];
    logic [CHAR_W-1:0]        n_win [CAP];
    logic [POSITION_BITS-1:0] r_pos;
    logic [POSITION_BITS-1:0] n_pos;
    logic                     r_out_valid;
    t_out_item                r_out_item;
    t_out_item                n_out_item;

    logic                     advance;
    logic [LEN_W-1:0]         eff_len;
    logic [POSITION_BITS-1:0] idx;
    logic                     at_max;
    logic                     long_enough;
    logic [CAP-1:0]           lane_ok;
    logic                     hit;
    logic [SW-1:0]            start_full;

    // Move the held beat when the result register is free or being taken
    assign o_ready = !r_out_valid || i_out_ready;
    assign advance = i_valid && o_ready;

    // Clamp the configured length into 1..CAP
    always_comb begin
        eff_len = i_cfg.pattern_length;
        if (eff_len == '0) begin
            eff_len = LEN_W'(1);
        end
        if (eff_len > LEN_W'(CAP)) begin
            eff_len = LEN_W'(CAP);
        end
    end

    // Shift in the new character; a sequence start clears the older entries
    always_comb begin
        n_win[0] = i_item.subject_char;
        for (int k = 1; k < CAP; k++) begin
            n_win[k] = i_item.first_of_sequence ? '0 : r_win[k-1];
        end
    end

    // Position of this character, saturating count for the next one
    assign idx         = i_item.first_of_sequence ? '0 : r_pos;
    assign at_max      = (idx == POS_MAX);
    assign n_pos       = at_max ? idx : idx + 1'b1;
    assign long_enough = at_max ||
        (({1'b0, idx} + (POSITION_BITS+1)'(1)) >= (POSITION_BITS+1)'(eff_len));

    // One compare lane per pattern character; lane i sees window entry len-1-i
    for (genvar i = 0; i < CAP; i++) begin : g_lane
        logic [LEN_W-1:0] sel;
        assign sel = eff_len - LEN_W'(1) - LEN_W'(i);
        assign lane_ok[i] = (LEN_W'(i) >= eff_len) ||
            char_matches(i_cfg.pattern_chars[CHAR_W*i +: CHAR_W],
                         n_win[sel[WIN_IDX_W-1:0]]);
    end

    assign hit        = long_enough && (&lane_ok);
    assign start_full = SW'(idx) - SW'(eff_len) + SW'(1);

    always_comb begin
        n_out_item.hit            = hit;
        n_out_item.start_position = hit ? start_full[START_W-1:0] : '0;
    end

    // Update window and position state on each advancing beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CAP; k++) begin
                r_win[k] <= '0;
            end
            r_pos <= '0;
        end else if (advance) begin
            for (int k = 0; k < CAP; k++) begin
                r_win[k] <= n_win[k];
            end
            r_pos <= n_pos;
        end
    end

    // Result register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_ready) begin
            r_out_valid <= i_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

    `IUPS_ASSERT_NOW(a_miss_zero_start, i_clk, i_rst_n,
        r_out_valid && !r_out_item.hit, r_out_item.start_position == '0,
        "miss result carries a nonzero start")
    `IUPS_ASSERT_NEXT(a_advance_fills, i_clk, i_rst_n, advance, r_out_valid,
        "advanced beat did not reach the result register")
    `IUPS_ASSERT_NEXT(a_pos_no_drop, i_clk, i_rst_n,
        advance && !i_item.first_of_sequence, r_pos >= $past(r_pos),
        "position count went backward")
    `IUPS_ASSERT_NEXT(a_pos_idle_hold, i_clk, i_rst_n, !advance, $stable(r_pos),
        "position count moved without a beat")

endmodule

`default_nettype wire

@@ rtl/core/iupac_pattern_search_unit.sv @@
// A character beat is held in the input register once it is accepted and
// then moves on to the result register, which presents its result beat.
// Throughput: one character per cycle while the output is ready; the input
// and result registers each hold one beat, so the lane compare sets the rate.
// Reset (synchronous, active low) clears the window, the position count and
// both valid flags, and loads pattern characters 0 and pattern length 1.
// ----------------------------------------------------------------------------
// IUPAC pattern search unit
// Streams subject characters and flags windows that match an IUPAC pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module iupac_pattern_search_unit
    import iups_pkg::*;
#(
    parameter int MAX_PATTERN   = 16,
    parameter int POSITION_BITS = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_item              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_data,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg     cfg;
    logic     held_valid;
    logic     held_ready;
    t_in_item held_item;

    // Configuration registers
    iups_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Input beat register
    iups_input_reg u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_item       (i_in_data),
        .o_valid      (held_valid),
        .i_down_ready (held_ready),
        .o_item       (held_item)
    );

    // Window, position and match into the result register
    iups_match_stage #(
        .MAX_PATTERN   (MAX_PATTERN),
        .POSITION_BITS (POSITION_BITS)
    ) u_match (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (held_valid),
        .o_ready     (held_ready),
        .i_item      (held_item),
        .i_cfg       (cfg),
        .o_valid     (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_item      (o_out_data)
    );

endmodule

`default_nettype wire

@@ tb/sv/iupac_pattern_search_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IUPAC pattern search unit testbench
// Streams subject characters through the search unit under a series of
// pattern settings. A scoreboard model of the shift window and position count
// predicts the hit and start position of every beat. The scoreboard then
// checks each result beat in order while both ports idle and stall at random.
// ----------------------------------------------------------------------------

module iupac_pattern_search_unit_test;
    import iups_pkg::*;

    localparam int                   WINDOW_DEPTH = 16;
    localparam logic [START_W-1:0]   POS_LIMIT    = '1;
    localparam logic [CFG_IDX_W-1:0] CFG_NONE     = 2'd3;
    localparam int                   HOLD_CYCLES  = 400;
    localparam int                   DRAIN_LIMIT  = 20000;
    localparam int                   TAIL_CYCLES  = 10;
    localparam int                   PHASES       = 12;
    localparam int                   PHASE_CHARS  = 115;

    typedef enum logic [1:0] {RX_STREAM, RX_COIN, RX_STARVE, RX_PATTERN} t_rx_mode;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in_item              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_PAT_LOW;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Scoreboard copy of the settings and of the sequence state
    logic [63:0]        pat_low     = '0;
    logic [63:0]        pat_high    = '0;
    logic [LEN_W-1:0]   pat_len_reg = 5'd1;
    logic [7:0]         seq_window [WINDOW_DEPTH];
    logic [START_W-1:0] seq_pos     = '0;

    t_in_item  pending_chars [$];
    t_out_item expected_matches [$];
    t_out_item want;
    int        errors     = 0;
    int        burst_left = 1;
    int        gap_left   = 0;
    int        hold_asks  = 0;
    int        hold_taken = 0;
    int        hold_left  = 0;
    t_rx_mode  rx_mode    = RX_STREAM;
    int        rx_mode_left = 0;
    logic [7:0] rx_pattern = 8'hFF;

    iupac_pattern_search_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return (c >= ASC_LOW_A && c <= ASC_LOW_Z) ? (c & ~ASC_CASE) : c;
    endfunction

    // Does an IUPAC code accept this subject byte; unknown codes match anything
    function automatic logic code_accepts(input logic [7:0] code, input logic [7:0] subj);
        logic [7:0] p;
        logic [7:0] s;
        p = fold_case(code);
        s = fold_case(subj);
        case (p)
            ASC_A, ASC_C, ASC_G, ASC_T, ASC_U: return s == p;
            ASC_Y: return s == ASC_C || s == ASC_T || s == ASC_U || s == ASC_Y;
            ASC_R: return s == ASC_A || s == ASC_G || s == ASC_R;
            ASC_W: return s == ASC_A || s == ASC_T || s == ASC_U || s == ASC_W;
            ASC_S: return s == ASC_C || s == ASC_G || s == ASC_S;
            ASC_K: return s == ASC_G || s == ASC_T || s == ASC_U || s == ASC_K;
            ASC_M: return s == ASC_C || s == ASC_A || s == ASC_M;
            ASC_B: return s == ASC_C || s == ASC_G || s == ASC_T || s == ASC_U || s == ASC_B;
            ASC_D: return s == ASC_A || s == ASC_G || s == ASC_T || s == ASC_U || s == ASC_D;
            ASC_H: return s == ASC_A || s == ASC_C || s == ASC_T || s == ASC_U || s == ASC_H;
            ASC_V: return s == ASC_A || s == ASC_C || s == ASC_G || s == ASC_V;
            default: return 1'b1;
        endcase
    endfunction

    // Clamp the length register: zero means one, anything past the window is full
    function automatic int active_length();
        if (pat_len_reg == 0) begin
            return 1;
        end
        if (pat_len_reg > WINDOW_DEPTH) begin
            return WINDOW_DEPTH;
        end
        return int'(pat_len_reg);
    endfunction

    // Advance the window by one character and compare the pattern against it
    function automatic t_out_item predict_match(input t_in_item beat);
        t_out_item          res;
        logic [127:0]       pat;
        logic [START_W-1:0] here;
        int                 span;
        logic               ok;
        int                 k;
        pat  = {pat_high, pat_low};
        span = active_length();
        if (beat.first_of_sequence) begin
            for (k = 0; k < WINDOW_DEPTH; k++) seq_window[k] = '0;
            seq_pos = '0;
        end
        for (k = WINDOW_DEPTH - 1; k > 0; k--) seq_window[k] = seq_window[k-1];
        seq_window[0] = beat.subject_char;
        here = seq_pos;
        if (seq_pos != POS_LIMIT) begin
            seq_pos++;
        end
        ok = ({32'd0, here} + 64'd1 >= 64'(span)) || (here == POS_LIMIT);
        // pattern character 0 lines up with the oldest character of the window
        for (k = 0; k < span && ok; k++) begin
            ok = code_accepts(pat[8*k +: 8], seq_window[span-1-k]);
        end
        res.hit            = ok;
        res.start_position = ok ? here - START_W'(span) + 1'b1 : '0;
        return res;
    endfunction

    function automatic logic [7:0] pick(input string opts);
        return opts[$urandom_range(0, opts.len() - 1)];
    endfunction

    function automatic logic [7:0] random_case(input logic [7:0] c);
        return $urandom_range(0, 1) ? (c | ASC_CASE) : c;
    endfunction

    // Pattern byte: mostly IUPAC codes, some N and some arbitrary bytes
    function automatic logic [7:0] random_code();
        case ($urandom_range(0, 9))
            0, 1:    return 8'($urandom);
            2:       return random_case(ASC_N);
            default: return random_case(pick("ACGTUYRWSKMBDHV"));
        endcase
    endfunction

    // Subject byte that the given pattern code accepts
    function automatic logic [7:0] fitting_char(input logic [7:0] code);
        logic [7:0] c;
        case (fold_case(code))
            ASC_A, ASC_C, ASC_G, ASC_T, ASC_U: c = fold_case(code);
            ASC_Y: c = pick("CTUY");
            ASC_R: c = pick("AGR");
            ASC_W: c = pick("ATUW");
            ASC_S: c = pick("CGS");
            ASC_K: c = pick("GTUK");
            ASC_M: c = pick("CAM");
            ASC_B: c = pick("CGTUB");
            ASC_D: c = pick("AGTUD");
            ASC_H: c = pick("ACTUH");
            ASC_V: c = pick("ACGV");
            default: return 8'($urandom);
        endcase
        return random_case(c);
    endfunction

    function automatic logic [7:0] background_char();
        case ($urandom_range(0, 9))
            0:       return 8'($urandom);
            1:       return random_case(pick("YRWSKMBDHVN"));
            default: return random_case(pick("ACGT"));
        endcase
    endfunction

    function automatic logic [63:0] random_pattern_word();
        logic [63:0] w;
        int          k;
        for (k = 0; k < 8; k++) w[8*k +: 8] = random_code();
        return w;
    endfunction

    task automatic queue_char(input logic [7:0] c, input logic first);
        t_in_item beat;
        beat.subject_char      = c;
        beat.first_of_sequence = first;
        pending_chars.insert(pending_chars.size(), beat);
    endtask

    // Mix of fresh sequences, embedded pattern copies (some with a flaw) and noise
    task automatic queue_random_chars(input int count);
        logic [127:0] pat;
        int           span;
        int           made;
        int           flaw;
        int           k;
        pat  = {pat_high, pat_low};
        span = active_length();
        made = 0;
        while (made < count) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    queue_char(background_char(), 1'b1);
                    made++;
                end
                2, 3, 4, 5: begin
                    flaw = ($urandom_range(0, 4) == 0) ? $urandom_range(0, span - 1) : -1;
                    for (k = 0; k < span; k++) begin
                        queue_char(k == flaw ? background_char() : fitting_char(pat[8*k +: 8]),
                                   1'b0);
                    end
                    made += span;
                end
                default: begin
                    queue_char(background_char(), $urandom_range(0, 31) == 0);
                    made++;
                end
            endcase
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_PAT_LOW:  pat_low = value;
            CFG_PAT_HIGH: pat_high = value;
            CFG_PAT_LEN:  pat_len_reg = value[LEN_W-1:0];
            default: ;
        endcase
    endtask

    // Hold until every queued character went in and every result came back
    task automatic wait_drained();
        int spins;
        spins = 0;
        while ((pending_chars.size() > 0 || in_valid || expected_matches.size() > 0)
               && spins < DRAIN_LIMIT) begin
            @(negedge clk);
            spins++;
        end
        repeat (3) @(negedge clk);
    endtask

    task automatic run_random_phase(input int count, input int len, input logic squeeze,
                                    input logic all_ones);
        logic [63:0] len_word;
        len_word = $urandom_range(0, 1) ? {$urandom, $urandom} : 64'd0;
        len_word[LEN_W-1:0] = (len < 0) ? LEN_W'($urandom_range(1, 16)) : LEN_W'(len);
        write_reg(CFG_PAT_LOW, all_ones ? '1 : random_pattern_word());
        write_reg(CFG_PAT_HIGH, all_ones ? '1 : random_pattern_word());
        write_reg(CFG_PAT_LEN, len_word);
        if ($urandom_range(0, 2) == 0) begin
            write_reg(CFG_NONE, {$urandom, $urandom});
        end
        @(negedge clk);
        if (squeeze) begin
            hold_asks++;
        end
        queue_random_chars(count);
        wait_drained();
    endtask

    // Driver: offer characters in bursts, hold each beat until it is taken
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                expected_matches.insert(expected_matches.size(), predict_match(in_data));
            end
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending_chars.size() > 0) begin
                    in_data  <= pending_chars.pop_front();
                    in_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 60);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall by mode, or hold off entirely when a long stall is requested
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (hold_asks != hold_taken) begin
                hold_taken = hold_asks;
                hold_left  = HOLD_CYCLES;
            end
            if (rx_mode_left == 0) begin
                rx_mode      = t_rx_mode'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(20, 200);
                rx_pattern   = 8'($urandom) | 8'h01;
            end else begin
                rx_mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_STREAM:  out_ready <= 1'b1;
                    RX_COIN:    out_ready <= 1'($urandom_range(0, 1));
                    RX_STARVE:  out_ready <= ($urandom_range(0, 3) == 0);
                    RX_PATTERN: begin
                        out_ready <= rx_pattern[0];
                        rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
                    end
                endcase
            end
        end
    end

    task automatic flag_mismatch(input string what, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        errors++;
        if (errors <= 10) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want_v, got_v);
        end
    endtask

    // Monitor: compare each result beat with the oldest prediction
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_matches.size() == 0) begin
                flag_mismatch("unexpected result", 32'd0, {31'd0, out_data.hit});
            end else begin
                want = expected_matches.pop_front();
                if (out_data.hit !== want.hit) begin
                    flag_mismatch("hit", {31'd0, want.hit}, {31'd0, out_data.hit});
                end
                if (out_data.start_position !== want.start_position) begin
                    flag_mismatch("start_position", want.start_position,
                                  out_data.start_position);
                end
            end
        end
    end

    initial begin : stimulus
        string dna;
        int    k;
        int    ph;
        int    len;
        for (k = 0; k < WINDOW_DEPTH; k++) seq_window[k] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: every pattern byte is a wildcard, length one
        queue_char(8'h00, 1'b1);
        queue_char(8'hFF, 1'b0);
        queue_char(8'h7F, 1'b1);
        wait_drained();

        // Each code against itself in lower case; hit only once the window fills
        write_reg(CFG_PAT_LOW, "YRUTGCAN");
        write_reg(CFG_PAT_HIGH, "VHDBMKWS");
        write_reg(CFG_PAT_LEN, 64'd16);
        @(negedge clk);
        dna = "nacgturyswkmbdhv";
        for (k = 0; k < dna.len(); k++) queue_char(dna[k], k == 0);
        wait_drained();

        // Length zero behaves as one
        write_reg(CFG_PAT_LOW, {56'd0, ASC_G});
        write_reg(CFG_PAT_LEN, 64'd0);
        @(negedge clk);
        queue_char(ASC_G, 1'b1);
        queue_char(ASC_G | ASC_CASE, 1'b0);
        queue_char(ASC_A, 1'b0);
        wait_drained();

        // Unused register index is dropped; oversize length clamps to the window
        write_reg(CFG_NONE, '1);
        write_reg(CFG_PAT_LEN, 64'd31);
        @(negedge clk);
        queue_char(ASC_T, 1'b0);
        queue_char(ASC_U, 1'b0);
        queue_char(ASC_C, 1'b0);
        wait_drained();

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       len = 16;
                1:       len = 1;
                2:       len = 0;
                3:       len = 31;
                4:       len = 8;
                7:       len = 17;
                9:       len = 16;
                default: len = -1;
            endcase
            run_random_phase(PHASE_CHARS, len, ph == 4, ph == 5);
        end

        repeat (TAIL_CYCLES) @(negedge clk);
        if (expected_matches.size() > 0) begin
            $display("%0d results never arrived", expected_matches.size());
            errors += expected_matches.size();
        end
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/iups_pkg.sv
rtl/core/iups_cfg_regs.sv
rtl/core/iups_input_reg.sv
rtl/core/iups_match_stage.sv
rtl/core/iupac_pattern_search_unit.sv
tb/sv/iupac_pattern_search_unit_test.sv
